### hdl/srb_pkg.sv
// Shared types, sizes and codes of the sequence reorder buffer.
package srb_pkg;

    // Number of slots in the reorder window and width of a stored payload.
    localparam int unsigned CAPACITY   = 16;
    localparam int unsigned DATA_WIDTH = 64;

    // Fixed field widths of the channels.
    localparam int unsigned OP_W     = 2;
    localparam int unsigned SEQ_W    = 32;
    localparam int unsigned PUT_W    = 64;
    localparam int unsigned STATUS_W = 3;

    // Slot index width and the slot count at one bit more than that width.
    localparam int unsigned SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [SLOT_W:0] CAP_EXT = (SLOT_W + 1)'(CAPACITY);

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [SEQ_W-1:0]    t_seq;
    typedef logic [DATA_WIDTH-1:0] t_data;

    // Operation codes.
    localparam t_op OP_PUT   = 2'd0;
    localparam t_op OP_GET   = 2'd1;
    localparam t_op OP_CLOSE = 2'd2;

    // Result status codes.
    localparam t_status ST_PUT_STORED    = 3'd0;
    localparam t_status ST_PUT_OUTSIDE   = 3'd1;
    localparam t_status ST_PUT_CLOSED    = 3'd2;
    localparam t_status ST_GET_DELIVERED = 3'd3;
    localparam t_status ST_GET_NOT_READY = 3'd4;
    localparam t_status ST_CLOSED_EMPTY  = 3'd5;
    localparam t_status ST_CLOSE_ACK     = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the input word and read the head slot
        logic execute;  // apply the operation and register the result
    } t_dp_cmd;

endpackage

### hdl/srb_if.sv
// Channel interfaces of the sequence reorder buffer: request and response.
interface srb_req_if
    import srb_pkg::*;
();
    logic              valid;
    logic              ready;
    t_op               op;
    logic [SEQ_W-1:0]  seq_index;
    logic [PUT_W-1:0]  put_data;

    modport source (output valid, output op, output seq_index, output put_data, input ready);
    modport sink   (input valid, input op, input seq_index, input put_data, output ready);
endinterface

interface srb_rsp_if
    import srb_pkg::*;
();
    logic              valid;
    logic              ready;
    t_status           status;
    logic [PUT_W-1:0]  out_data;
    logic [SEQ_W-1:0]  out_seq;

    modport source (output valid, output status, output out_data, output out_seq, input ready);
    modport sink   (input valid, input status, input out_data, input out_seq, output ready);
endinterface

### hdl/srb_ctrl.sv
// Controller of the sequence reorder buffer: handshakes and step sequencing.
module srb_ctrl
    import srb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // Handshake outputs follow the state directly; no word is taken during reset.
    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid = (r_state == S_OUT);

    assign o_cmd.load    = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.execute = (r_state == S_EXEC);

    // Next state: take a word, work on it, hold the result until taken.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hdl/srb_datapath.sv
// Datapath of the sequence reorder buffer: payload store, window and result.
module srb_datapath
    import srb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  t_op              i_op,
    input  logic [SEQ_W-1:0] i_seq_index,
    input  logic [PUT_W-1:0] i_put_data,
    output t_status          o_status,
    output logic [PUT_W-1:0] o_out_data,
    output logic [SEQ_W-1:0] o_out_seq
);

    // Payload memory; the head entry is read on every load but used only when its slot is ready.
    t_data r_mem [CAPACITY];
    t_data r_rd_data;

    // Captured input word.
    t_op   r_op;
    t_seq  r_seq;
    t_data r_data;

    // Buffer state.
    logic [CAPACITY-1:0] r_slot_ready;
    logic [CAPACITY-1:0] n_slot_ready;
    t_seq  r_next_exp;
    t_seq  n_next_exp;
    t_slot r_next_slot;
    t_slot n_next_slot;
    logic  r_closed;
    logic  n_closed;

    // Result registers.
    t_status          r_status;
    t_status          n_status;
    logic [PUT_W-1:0] r_out_data;
    logic [PUT_W-1:0] n_out_data;
    t_seq             r_out_seq;
    t_seq             n_out_seq;

    // Window test and put slot.
    t_seq            diff;
    logic            seq_in_range;
    logic [SLOT_W:0] slot_sum;
    t_slot           put_slot;
    logic            mem_we;
    logic            head_ready;

    // The put slot is the head slot plus the distance into the window.
    assign diff         = r_seq - r_next_exp;
    assign seq_in_range = (diff < SEQ_W'(CAPACITY));
    assign slot_sum     = {1'b0, r_next_slot} + {1'b0, diff[SLOT_W-1:0]};
    assign put_slot     = (slot_sum >= CAP_EXT) ? SLOT_W'(slot_sum - CAP_EXT)
                                                : slot_sum[SLOT_W-1:0];
    assign head_ready   = r_slot_ready[r_next_slot];

    // Operation decode and state update.
    always_comb begin
        n_slot_ready = r_slot_ready;
        n_next_exp   = r_next_exp;
        n_next_slot  = r_next_slot;
        n_closed     = r_closed;
        n_status     = ST_GET_NOT_READY;
        n_out_data   = '0;
        n_out_seq    = '0;
        mem_we       = 1'b0;
        case (r_op)
            OP_PUT: begin
                if (r_closed) begin
                    n_status = ST_PUT_CLOSED;
                end else if (seq_in_range) begin
                    mem_we                 = 1'b1;
                    n_slot_ready[put_slot] = 1'b1;
                    n_status               = ST_PUT_STORED;
                end else begin
                    n_status = ST_PUT_OUTSIDE;
                end
            end
            OP_GET: begin
                if (head_ready) begin
                    n_out_data                = PUT_W'(r_rd_data);
                    n_out_seq                 = r_next_exp;
                    n_slot_ready[r_next_slot] = 1'b0;
                    n_next_exp                = r_next_exp + 1'b1;
                    // Sequence wrap lands on slot zero for any capacity.
                    if (r_next_exp == '1 ||
                        r_next_slot == SLOT_W'(CAPACITY - 1)) begin
                        n_next_slot = '0;
                    end else begin
                        n_next_slot = r_next_slot + 1'b1;
                    end
                    n_status = ST_GET_DELIVERED;
                end else if (r_closed) begin
                    n_status = ST_CLOSED_EMPTY;
                end else begin
                    n_status = ST_GET_NOT_READY;
                end
            end
            OP_CLOSE: begin
                n_closed = 1'b1;
                n_status = ST_CLOSE_ACK;
            end
            default: begin
                n_status = ST_GET_NOT_READY;
            end
        endcase
    end

    // Input capture and head slot read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_op;
            r_seq     <= i_seq_index;
            r_data    <= DATA_WIDTH'(i_put_data);
            r_rd_data <= r_mem[r_next_slot];
        end
    end

    // Payload write on a stored put.
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && mem_we) begin
            r_mem[put_slot] <= r_data;
        end
    end

    // Control state of the buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_ready <= '0;
            r_next_exp   <= '0;
            r_next_slot  <= '0;
            r_closed     <= 1'b0;
        end else if (i_cmd.execute) begin
            r_slot_ready <= n_slot_ready;
            r_next_exp   <= n_next_exp;
            r_next_slot  <= n_next_slot;
            r_closed     <= n_closed;
        end
    end

    // Result word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_status   <= n_status;
            r_out_data <= n_out_data;
            r_out_seq  <= n_out_seq;
        end
    end

    assign o_status   = r_status;
    assign o_out_data = r_out_data;
    assign o_out_seq  = r_out_seq;

endmodule

### hdl/sequence_reorder_buffer.sv
// Top level of the sequence reorder buffer.
//
// Usage: each request word on i_req carries an op (put, get or close), a
// sequence number and a payload. Each request yields exactly one response
// word on o_rsp with a status, the released payload and its sequence number.
// A put stores its payload if the sequence number lies in the window of
// CAPACITY numbers starting at the next expected one; a get releases the
// next expected payload once it is present, so payloads leave in order.
// After a close, puts are dropped and gets drain the waiting payloads.
// Timing: a request is taken in the idle state, worked on in the next
// cycle, and its response is valid from the cycle after that. One request
// is in flight at a time, so no new request is taken until the response
// has been accepted; the payload memory read and the result are both
// registered. While the receiver stalls, the response holds and no
// new request is taken. Reset clears the ready bits, the expected
// sequence number and the closed flag; no clearing pass is needed, and
// no request is taken while reset is held.
module sequence_reorder_buffer
    import srb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    srb_req_if.sink  i_req,
    srb_rsp_if.source o_rsp
);

    t_dp_cmd cmd;
    logic    in_ready;
    logic    out_valid;

    // Sequencing of the handshakes.
    srb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    // Buffer storage and result computation.
    srb_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_op        (i_req.op),
        .i_seq_index (i_req.seq_index),
        .i_put_data  (i_req.put_data),
        .o_status    (o_rsp.status),
        .o_out_data  (o_rsp.out_data),
        .o_out_seq   (o_rsp.out_seq)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;

endmodule
